// ===== hw/rtl/srr_pkg.sv =====
// Shared types and constants of the selective-repeat receiver.
`timescale 1ns / 1ps
`default_nettype none
package srr_pkg;

  localparam int WINDOW      = 4;
  localparam int SEQ_BITS    = 16;
  localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int SPAN_BITS  = 3;
  localparam int TOTAL_BITS = 16;
  localparam int CFG_BITS   = 16;

  localparam logic [SPAN_BITS-1:0]  SPAN_RESET  = SPAN_BITS'(4);
  localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = TOTAL_BITS'(27);

  typedef enum logic {
    REG_WINDOW_SPAN  = 1'b0,
    REG_TOTAL_FRAMES = 1'b1
  } srr_reg_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_NACK    = 2'd1,
    KIND_DELIVER = 2'd2
  } srr_kind_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic [31:0]         payload;
    logic                frame_ok;
  } srr_in_t;

  typedef struct packed {
    srr_kind_t           reply_kind;
    logic [SEQ_BITS-1:0] frame_seq;
    logic [31:0]         frame_word;
    logic                last_of_run;
  } srr_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } srr_q_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/srr_queue.sv =====
// Short result queue between the frame classifier and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module srr_queue
  import srr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  srr_out_t         push_item,
  input  wire logic        pop,
  output srr_out_t         pop_item,
  output srr_q_stat_t      stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  srr_out_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/srr_front.sv =====
// Frame classifier, reorder slots and in-order delivery sequencer.
`timescale 1ns / 1ps
`default_nettype none
module srr_front
  import srr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  srr_in_t                  in_item,
  input  srr_q_stat_t              q_stat,
  output logic                     push,
  output srr_out_t                 push_item
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t                  state;
  logic [SPAN_BITS-1:0]    window_span;
  logic [TOTAL_BITS-1:0]   total_frames;
  logic [SEQ_BITS-1:0]     next_expected;
  logic [IDX_W-1:0]        head;
  logic                    slot_full [WINDOW];
  logic [31:0]             slot_word [WINDOW];

  logic [SEQ_BITS-1:0]     span_ext;
  logic [SEQ_BITS-1:0]     diff;
  logic                    is_old;
  logic                    is_outside;
  logic                    store;
  logic [IDX_W:0]          idx_sum;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        head_next;
  logic                    accept;
  srr_out_t                reply_item;
  srr_out_t                deliver_item;

  always_comb begin
    if (window_span == '0) begin
      span_ext = SEQ_BITS'(1);
    end else if (32'(window_span) > WINDOW) begin
      span_ext = SEQ_BITS'(WINDOW);
    end else begin
      span_ext = SEQ_BITS'(window_span);
    end
  end

  assign diff       = in_item.seq - next_expected;
  assign is_old     = in_item.seq < next_expected;
  assign is_outside = (diff >= span_ext) || (32'(in_item.seq) >= 32'(total_frames));
  assign store      = in_item.frame_ok && !is_old && !is_outside;

  assign idx_sum = {1'b0, head} + diff[IDX_W:0];
  assign idx     = (idx_sum >= (IDX_W + 1)'(WINDOW)) ?
                   IDX_W'(idx_sum - (IDX_W + 1)'(WINDOW)) : idx_sum[IDX_W-1:0];

  assign head_next = (head == IDX_W'(WINDOW - 1)) ? '0 : head + 1'b1;

  always_comb begin
    reply_item.frame_seq   = in_item.seq;
    reply_item.frame_word  = '0;
    reply_item.last_of_run = !(store && ((in_item.seq == next_expected) || slot_full[head]));
    if (!in_item.frame_ok) begin
      reply_item.reply_kind = KIND_NACK;
    end else if (is_old) begin
      reply_item.reply_kind = KIND_ACK;
    end else if (is_outside) begin
      reply_item.reply_kind = KIND_NACK;
    end else begin
      reply_item.reply_kind = KIND_ACK;
    end
  end

  assign deliver_item.reply_kind  = KIND_DELIVER;
  assign deliver_item.frame_seq   = next_expected;
  assign deliver_item.frame_word  = slot_word[head];
  assign deliver_item.last_of_run = !((head_next != head) && slot_full[head_next]);

  assign in_stall  = (state != S_IDLE) || q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = (state == S_IDLE) ? accept : !q_stat.full;
  assign push_item = (state == S_IDLE) ? reply_item : deliver_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_span   <= SPAN_RESET;
      total_frames  <= TOTAL_RESET;
      next_expected <= '0;
      head          <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        slot_full[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_WINDOW_SPAN:  window_span  <= cfg_data[SPAN_BITS-1:0];
          REG_TOTAL_FRAMES: total_frames <= cfg_data[TOTAL_BITS-1:0];
          default:          ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && store) begin
            slot_full[idx] <= 1'b1;
            if (!reply_item.last_of_run) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (!q_stat.full) begin
            slot_full[head] <= 1'b0;
            next_expected   <= next_expected + 1'b1;
            head            <= head_next;
            if (deliver_item.last_of_run) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && store) begin
      slot_word[idx] <= in_item.payload;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/srr_back.sv =====
// Output stage: drains the result queue into a held output register.
`timescale 1ns / 1ps
`default_nettype none
module srr_back
  import srr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  srr_q_stat_t q_stat,
  input  srr_out_t    q_item,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output srr_out_t    out_item
);

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= q_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver.
`timescale 1ns / 1ps
`default_nettype none
// Receiver side of selective-repeat ARQ. Each accepted item is one arriving
// frame; it first yields an ACK or NACK item, and a frame that completes the
// in-order run then releases one delivered-frame item per stored slot, the
// final one marked last_of_run (up to WINDOW of them). Input stalls while
// the delivery sequencer reads one reorder slot per cycle, whenever the
// result queue is not full; a 2-entry result queue and an output register
// let input and output stall independently. Configuration writes take
// effect at the next edge and must be issued while the block is idle.
module selective_repeat_receiver
  import srr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  srr_in_t                  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srr_out_t                 out_item
);

  srr_q_stat_t q_stat;
  logic        push;
  srr_out_t    push_item;
  logic        pop;
  srr_out_t    pop_item;

  srr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  srr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  srr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_item    (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
